// ----- hw/rtl/cdq_pkg.sv -----
// Shared types and codes for the circular deque unit.
// No dependencies; imported by cdq_ctrl, cdq_datapath and circular_deque_unit.
package cdq_pkg;

  // Request codes as carried on req_type_i.
  typedef enum logic [1:0] {
    REQ_PUSH_REAR  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_e;

  // Result status codes as carried on status_o.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request fields
    logic push_rear;
    logic push_front;
    logic pop_front;
    logic pop_rear;
    logic refuse_full;
    logic refuse_empty;
  } cdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_e req;
    logic full;
    logic empty;
  } cdq_stat_t;

endpackage

// ----- hw/rtl/cdq_ctrl.sv -----
// Controller of the circular deque: sequences capture, execution and response.
// Depends on cdq_pkg for the command and status structs.
module cdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  input  cdq_pkg::cdq_stat_t stat_i,
  output cdq_pkg::cdq_cmd_t  cmd_o
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (stat_i.req)
          REQ_PUSH_REAR: begin
            cmd_o.refuse_full = stat_i.full;
            cmd_o.push_rear   = !stat_i.full;
          end
          REQ_PUSH_FRONT: begin
            cmd_o.refuse_full = stat_i.full;
            cmd_o.push_front  = !stat_i.full;
          end
          REQ_POP_FRONT: begin
            cmd_o.refuse_empty = stat_i.empty;
            cmd_o.pop_front    = !stat_i.empty;
          end
          REQ_POP_REAR: begin
            cmd_o.refuse_empty = stat_i.empty;
            cmd_o.pop_rear     = !stat_i.empty;
          end
          default: ;
        endcase
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_EXEC);
    end
  end

  // Exactly one operation is issued in the execute state.
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $onehot({cmd_o.push_rear, cmd_o.push_front, cmd_o.pop_front,
                                      cmd_o.pop_rear, cmd_o.refuse_full, cmd_o.refuse_empty}))
    else $error("cdq_ctrl: execute state did not issue exactly one operation");

  // An accepted request produces its strobe after the execute state, in the response state.
  a_resp_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("cdq_ctrl: result strobe missing after accepted request");

  // The strobe is only ever shown in the response state.
  a_done_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == ST_RESP))
    else $error("cdq_ctrl: result strobe outside the response state");

endmodule

// ----- hw/rtl/cdq_datapath.sv -----
// Datapath of the circular deque: store, front and rear indices, word count
// and result registers. Depends on cdq_pkg; driven by cdq_ctrl commands.
module cdq_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cdq_pkg::REQ_W-1:0]         req_type_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] push_value_i,
  input  cdq_pkg::cdq_cmd_t                 cmd_i,
  output cdq_pkg::cdq_stat_t                stat_o,
  output logic [1:0]                        status_o,
  output logic signed [cdq_pkg::WORD_W-1:0] popped_value_o,
  output logic [cdq_pkg::OCC_W-1:0]         occupancy_o
);
  import cdq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  req_e                  req_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [1:0]            status_q;
  logic                  pop_ok_q;
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic [IDX_W-1:0] waddr, raddr;
  logic             we, re;

  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

  assign stat_o.req   = req_q;
  assign stat_o.full  = (count_q == FULL_CNT);
  assign stat_o.empty = (count_q == '0);

  // A push at the front writes below the head; a pop at the rear reads below the tail.
  assign we    = cmd_i.push_rear | cmd_i.push_front;
  assign re    = cmd_i.pop_front | cmd_i.pop_rear;
  assign waddr = cmd_i.push_front ? head_dec : tail_q;
  assign raddr = cmd_i.pop_rear ? tail_dec : head_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.push_rear) begin
      tail_d  = tail_inc;
      count_d = count_q + 1'b1;
    end else if (cmd_i.push_front) begin
      head_d  = head_dec;
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop_front) begin
      head_d  = head_inc;
      count_d = count_q - 1'b1;
    end else if (cmd_i.pop_rear) begin
      tail_d  = tail_dec;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      pop_ok_q <= 1'b0;
      status_q <= STATUS_DONE;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (we || re || cmd_i.refuse_full || cmd_i.refuse_empty) begin
        pop_ok_q <= re;
        if (cmd_i.refuse_full) begin
          status_q <= STATUS_FULL;
        end else if (cmd_i.refuse_empty) begin
          status_q <= STATUS_EMPTY;
        end else begin
          status_q <= STATUS_DONE;
        end
      end
    end
  end

  // Request capture; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_e'(req_type_i);
      wdata_q <= DATA_WIDTH'($unsigned(push_value_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata_q;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign status_o       = status_q;
  assign popped_value_o = pop_ok_q ? $signed(WORD_W'(rdata_q)) : '0;
  assign occupancy_o    = OCC_W'(count_q);

  // Tail always sits count words past the head, modulo the depth.
  logic [IDX_W:0] span_sum;
  logic [IDX_W:0] span_wrap;
  assign span_sum  = (IDX_W + 1)'(head_q) + (IDX_W + 1)'(count_q);
  assign span_wrap = (span_sum >= (IDX_W + 1)'(DEPTH)) ? span_sum - (IDX_W + 1)'(DEPTH)
                                                       : span_sum;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("cdq_datapath: word count exceeds depth");

  a_index_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == IDX_W'(span_wrap))
    else $error("cdq_datapath: tail index inconsistent with head and count");

  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.refuse_full || cmd_i.refuse_empty) |=>
      ($stable(count_q) && $stable(head_q) && $stable(tail_q)))
    else $error("cdq_datapath: refused request changed the deque");

endmodule

// ----- hw/rtl/circular_deque_unit.sv -----
// Circular deque unit: push or pop at either end of a circular store.
// Result: the strobe done_o is registered from the execute state and is high in the
// response state that follows it, where the receiver takes each result.
// Requests: a new request is taken only in the idle state; busy_o is high while the
// three-state controller sequences the single store access with its registered read data.
// Reset clears the indices and word count (empty deque); store contents are not cleared.
// The receiver cannot stall: the result strobe is shown for one cycle only.
module circular_deque_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [cdq_pkg::REQ_W-1:0]         req_type_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] push_value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic signed [cdq_pkg::WORD_W-1:0] popped_value_o,
  output logic [cdq_pkg::OCC_W-1:0]         occupancy_o
);
  import cdq_pkg::*;

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  cdq_datapath #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_type_i),
    .push_value_i  (push_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .occupancy_o   (occupancy_o)
  );

endmodule
